// ===== rtl/lac_pkg.sv =====
// Package for the layer alpha compositor: beat payload types and constants.
// No dependencies; imported by lac_blend, layer_alpha_compositor and both test files.
package lac_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COORD_W = 12;

    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

    // One layer of a pixel's stack, bottom layer first.
    typedef struct packed {
        logic [CHAN_W-1:0]  layer_red;
        logic [CHAN_W-1:0]  layer_green;
        logic [CHAN_W-1:0]  layer_blue;
        logic [CHAN_W-1:0]  layer_alpha;
        logic               top_layer;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_layer;

    // One composited pixel.
    typedef struct packed {
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
        logic [CHAN_W-1:0]  out_alpha;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } t_pixel;

    // Accumulated colour of the stack so far.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rgba;

endpackage

// ===== rtl/lac_blend.sv =====
// Source-over blend of one layer onto the accumulator, purely combinational.
// Depends on lac_pkg for the layer and accumulator types.
module lac_blend (
    input  lac_pkg::t_layer i_layer,
    input  lac_pkg::t_rgba  i_acc,
    input  logic            i_start,
    output lac_pkg::t_rgba  o_acc
);
    import lac_pkg::*;

    // Exact floor(t / 255) for t below 65280, by reciprocal multiply and shift.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] t);
        logic [16:0] s;
        begin
            s = {1'b0, t} + {9'd0, t[15:8]} + 17'd1;
            div255 = s[15:8];
        end
    endfunction

    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] acc,
                                              input logic [CHAN_W-1:0] c,
                                              input logic [CHAN_W-1:0] a);
        logic [15:0] p;
        begin
            p = (16'(c) * 16'(a)) + (16'(acc) * 16'(ALPHA_FULL - a)) + 16'd127;
            mix = div255(p);
        end
    endfunction

    logic [CHAN_W-1:0] inv_alpha;
    logic [15:0]       alpha_prod;

    assign inv_alpha  = ALPHA_FULL - i_layer.layer_alpha;
    assign alpha_prod = 16'(i_acc.alpha) * 16'(inv_alpha);

    always_comb begin
        if (i_start) begin
            // The bottom layer seeds the stack and is treated as solid.
            o_acc.red   = i_layer.layer_red;
            o_acc.green = i_layer.layer_green;
            o_acc.blue  = i_layer.layer_blue;
            o_acc.alpha = ALPHA_FULL;
        end else begin
            o_acc.red   = mix(i_acc.red,   i_layer.layer_red,   i_layer.layer_alpha);
            o_acc.green = mix(i_acc.green, i_layer.layer_green, i_layer.layer_alpha);
            o_acc.blue  = mix(i_acc.blue,  i_layer.layer_blue,  i_layer.layer_alpha);
            o_acc.alpha = i_layer.layer_alpha + div255(alpha_prod);
        end
    end

endmodule

// ===== rtl/layer_alpha_compositor.sv =====
// Layer alpha compositor top level: input register, blend, accumulator, result register.
// Depends on lac_pkg and lac_blend.
//
//  channel  | direction | payload          | beat
//  ---------+-----------+------------------+--------------------------------------
//  in       | sink      | lac_pkg::t_layer | one layer, bottom first, top_layer ends
//  out      | source    | lac_pkg::t_pixel | one composited pixel per stack
//
// One layer beat is taken every cycle while no top layer is held; the accumulator loop
// (two 8x8 products, an add and a reciprocal divide by 255) holds no register but the accumulator.
// A top layer beat goes through the input register and then the result register to the result beat.
// A top layer waits in the input register only while the result register is full
// and not being drained; lower layers never wait.
// Synchronous active-low reset empties both registers and marks the next beat
// as a bottom layer.
module layer_alpha_compositor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lac_pkg::t_layer i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lac_pkg::t_pixel o_out_data
);
    import lac_pkg::*;

    logic   r_in_valid;
    t_layer r_in;
    logic   r_start;
    t_rgba  r_acc;
    logic   r_out_valid;
    t_pixel r_out;

    t_rgba  n_acc;
    logic   proc;
    logic   out_free;

    lac_blend u_blend (
        .i_layer (r_in),
        .i_acc   (r_acc),
        .i_start (r_start),
        .o_acc   (n_acc)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // A held layer goes through when it produces no result or the result slot frees.
    assign proc       = r_in_valid && (!r_in.top_layer || out_free);
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_acc   <= '0;
        end else if (proc) begin
            r_start <= r_in.top_layer;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in.top_layer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in.top_layer) begin
            r_out.out_red   <= n_acc.red;
            r_out.out_green <= n_acc.green;
            r_out.out_blue  <= n_acc.blue;
            r_out.out_alpha <= n_acc.alpha;
            r_out.out_x     <= r_in.pixel_x;
            r_out.out_y     <= r_in.pixel_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_top_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.top_layer |=> r_out_valid)
        else $error("top layer did not produce a result beat");

    a_top_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.top_layer |=> r_start)
        else $error("stack start not set after top layer");

    a_lower_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && !r_in.top_layer |=> !r_start)
        else $error("stack start set after a lower layer");

    a_held_layer_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc |=> r_in_valid && $stable(r_in))
        else $error("stalled layer lost from input register");

    a_stall_only_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_out_valid && !i_out_ready && r_in.top_layer)
        else $error("input stalled without a blocked result");

endmodule

// ===== test/layer_alpha_compositor_check.sv =====
// Checker for the layer alpha compositor: watches both channels, predicts each pixel.
// Depends on lac_pkg; instantiated beside the block by layer_alpha_compositor_test.
`timescale 1ns / 100ps

module layer_alpha_compositor_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  lac_pkg::t_layer i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  lac_pkg::t_pixel i_out_data,
    output int              o_errors,
    output int              o_pending
);
    import lac_pkg::*;

    t_rgba  stack_acc;
    logic   stack_start;
    t_pixel pixel_expected[$];

    initial o_errors = 0;
    assign o_pending = pixel_expected.size();

    // Rounded source-over mix; 255 is odd, so no exact halves arise.
    function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] under,
                                                     logic [CHAN_W-1:0] over,
                                                     logic [CHAN_W-1:0] a);
        logic [16:0] sum;
        sum = 17'(over) * 17'(a) + 17'(under) * 17'(ALPHA_FULL - a) + 17'd127;
        return CHAN_W'(sum / 17'd255);
    endfunction

    function automatic logic [CHAN_W-1:0] blend_alpha(logic [CHAN_W-1:0] under,
                                                      logic [CHAN_W-1:0] a);
        return CHAN_W'(17'(a) + (17'(under) * 17'(ALPHA_FULL - a)) / 17'd255);
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                               input logic [COORD_W-1:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic composite_layer(input t_layer l);
        t_pixel px;
        if (stack_start) begin
            stack_acc = '{red: l.layer_red, green: l.layer_green,
                          blue: l.layer_blue, alpha: ALPHA_FULL};
        end else begin
            stack_acc.red   = blend_chan(stack_acc.red,   l.layer_red,   l.layer_alpha);
            stack_acc.green = blend_chan(stack_acc.green, l.layer_green, l.layer_alpha);
            stack_acc.blue  = blend_chan(stack_acc.blue,  l.layer_blue,  l.layer_alpha);
            stack_acc.alpha = blend_alpha(stack_acc.alpha, l.layer_alpha);
        end
        stack_start = l.top_layer;
        if (l.top_layer) begin
            px.out_red   = stack_acc.red;
            px.out_green = stack_acc.green;
            px.out_blue  = stack_acc.blue;
            px.out_alpha = stack_acc.alpha;
            px.out_x     = l.pixel_x;
            px.out_y     = l.pixel_y;
            pixel_expected.push_back(px);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_acc   = '0;
            stack_start = 1'b1;
            pixel_expected.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                composite_layer(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_expected.size() == 0) begin
                    report("pixel beat arrived with nothing expected");
                end else begin
                    t_pixel want;
                    want = pixel_expected.pop_front();
                    check_field("out_red",   COORD_W'(i_out_data.out_red),
                                COORD_W'(want.out_red));
                    check_field("out_green", COORD_W'(i_out_data.out_green),
                                COORD_W'(want.out_green));
                    check_field("out_blue",  COORD_W'(i_out_data.out_blue),
                                COORD_W'(want.out_blue));
                    check_field("out_alpha", COORD_W'(i_out_data.out_alpha),
                                COORD_W'(want.out_alpha));
                    check_field("out_x",     i_out_data.out_x,     want.out_x);
                    check_field("out_y",     i_out_data.out_y,     want.out_y);
                end
            end
        end
    end

endmodule

// ===== test/layer_alpha_compositor_test.sv =====
// Testbench top for the layer alpha compositor: clock, reset, layer stimulus, verdict.
// Depends on lac_pkg, layer_alpha_compositor and layer_alpha_compositor_check.
`timescale 1ns / 100ps

module layer_alpha_compositor_test;
    import lac_pkg::*;

    localparam int LAYER_TARGET = 650;
    localparam int CYCLE_LIMIT  = 200000;

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   in_valid  = 1'b0;
    t_layer in_data   = '0;
    logic   out_ready = 1'b0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_pixel o_out_data;

    int n_errors;
    int n_pending;
    int layers_sent = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;

    layer_alpha_compositor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    layer_alpha_compositor_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_layer make_layer(int r, int g, int b, int a, bit top,
                                          int x, int y);
        t_layer l;
        l.layer_red   = CHAN_W'(r);
        l.layer_green = CHAN_W'(g);
        l.layer_blue  = CHAN_W'(b);
        l.layer_alpha = CHAN_W'(a);
        l.top_layer   = top;
        l.pixel_x     = COORD_W'(x);
        l.pixel_y     = COORD_W'(y);
        return l;
    endfunction

    // Fully transparent and solid layers are favoured so the replace and
    // pass-through paths come up often.
    function automatic t_layer random_layer(bit top);
        int a;
        case ($urandom_range(0, 5))
            0: begin
                a = 0;
            end
            1: begin
                a = 255;
            end
            default: begin
                a = $urandom_range(0, 255);
            end
        endcase
        return make_layer($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), a, top,
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
    endfunction

    // Valid stays high across back-to-back beats; it only drops for a gap.
    task automatic send_layer(input t_layer l);
        int gap;
        gap = idle_draw();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= l;
        do @(posedge i_clk); while (!o_in_ready);
        layers_sent++;
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_draw();
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int depth;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-layer stacks: colour passes through, alpha is forced solid.
        send_layer(make_layer(255, 0, 255, 0, 1'b1, 4095, 0));
        send_layer(make_layer(0, 0, 0, 0, 1'b1, 0, 4095));
        // A solid top layer replaces the bottom.
        send_layer(make_layer(10, 20, 30, 0, 1'b0, 4095, 4095));
        send_layer(make_layer(200, 100, 50, 255, 1'b1, 1, 2));
        // A fully transparent top layer leaves the bottom untouched.
        send_layer(make_layer(255, 255, 255, 128, 1'b0, 0, 0));
        send_layer(make_layer(0, 0, 0, 0, 1'b1, 2730, 1365));
        // Coordinates on lower layers must not leak into the result.
        send_layer(make_layer(0, 255, 0, 255, 1'b0, 4095, 4095));
        send_layer(make_layer(255, 0, 255, 1, 1'b0, 4095, 4095));
        send_layer(make_layer(128, 128, 128, 254, 1'b1, 0, 0));
        // Rounding either side of the half-way point.
        send_layer(make_layer(0, 0, 0, 255, 1'b0, 17, 34));
        send_layer(make_layer(255, 255, 255, 127, 1'b0, 51, 68));
        send_layer(make_layer(255, 255, 255, 128, 1'b1, 85, 102));
        send_layer(make_layer(255, 255, 255, 9, 1'b0, 3, 4));
        send_layer(make_layer(0, 255, 0, 255, 1'b0, 5, 6));
        send_layer(make_layer(255, 0, 255, 128, 1'b0, 7, 8));
        send_layer(make_layer(85, 170, 15, 200, 1'b0, 9, 10));
        send_layer(make_layer(240, 15, 90, 55, 1'b1, 4094, 2049));

        while (layers_sent < LAYER_TARGET) begin
            if ($urandom_range(0, 15) == 0) begin
                no_idle = !no_idle;
            end
            if ($urandom_range(0, 9) == 0) begin
                depth = $urandom_range(9, 24);
            end else begin
                depth = $urandom_range(1, 6);
            end
            for (int i = 0; i < depth; i++) begin
                send_layer(random_layer(i == depth - 1));
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lac_pkg.sv
rtl/lac_blend.sv
rtl/layer_alpha_compositor.sv
test/layer_alpha_compositor_check.sv
test/layer_alpha_compositor_test.sv
